@@ rtl/core/plbt_pkg.sv @@
// ----------------------------------------------------------------------------
// plbt_pkg
// Shared widths, command and register codes, and types for the palette
// line blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package plbt_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 8;
    localparam int COLOR_W    = 16;
    localparam int COORD_W    = 10;
    localparam int COLUMN_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // palette depth default and upper clip bound on the line width
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_LINE            = 1024;

    // display width after reset
    localparam logic [COORD_W-1:0] DISPLAY_WIDTH_RST = COORD_W'(128);

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PALETTE = 2'd0,
        CMD_LINE    = 2'd1,
        CMD_PIXEL   = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSPARENT_INDEX = 3'd0,
        CFG_BACKGROUND_INDEX  = 3'd1,
        CFG_TRANSPARENCY_EN   = 3'd2,
        CFG_RESTORE_BG        = 3'd3,
        CFG_DISPLAY_WIDTH     = 3'd4
    } cfg_reg_t;

    // configuration register set
    typedef struct packed {
        logic [IDX_W-1:0]   transparent_index;
        logic [IDX_W-1:0]   background_index;
        logic               transparency_enable;
        logic               restore_background;
        logic [COORD_W-1:0] display_width;
    } cfg_t;

    // palette lookup issued by the line control for a drawn pixel
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    index;
        logic [COLUMN_W-1:0] column;
        logic [COORD_W-1:0]  row;
    } lookup_t;

endpackage

`default_nettype wire

@@ rtl/core/plbt_if.sv @@
// ----------------------------------------------------------------------------
// plbt_if
// Valid/ready channel interfaces for requests and pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface plbt_request_if
    import plbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    index;
    logic [COLOR_W-1:0]  color;
    logic [COORD_W-1:0]  origin_x;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  line_width;

    modport source (
        output valid, command, index, color, origin_x, row, line_width,
        input  ready
    );
    modport sink (
        input  valid, command, index, color, origin_x, row, line_width,
        output ready
    );
endinterface

interface plbt_response_if
    import plbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [COLOR_W-1:0]  pixel_color;
    logic [COLUMN_W-1:0] column;
    logic [COORD_W-1:0]  row_out;

    modport source (
        output valid, pixel_color, column, row_out,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, column, row_out,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/palette_line_blit_transparency_core.sv @@
// ----------------------------------------------------------------------------
// palette_line_blit_transparency_core
// Expands palette-indexed pixels of one line into byte-swapped RGB565 writes.
//
// request channel: one transaction per command. A palette write stores a
// color, a line start sets origin column, row and clipped width, a pixel
// is looked up and gives at most one write on the response channel
// (color, column, row). A transparent-index pixel takes the background
// index if restore is set, else with transparency on it is skipped but
// takes up a column; pixels past the clipped width are dropped.
// Throughput: one request per cycle while request.ready is high. A pixel's
// write passes the palette read, then the output register.
// Stall: the output register and the lookup stage each hold one result;
// request.ready falls only when both are full and response.ready is low.
// Reset clears the line state and loads the register defaults (display
// width 128); the palette holds nothing valid until written. The user
// must write registers on the cfg port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_line_blit_transparency_core
    import plbt_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    plbt_request_if.sink               request,
    plbt_response_if.source            response,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    lookup_t lookup;
    logic    accept;
    logic    free;
    logic    pal_we;
    logic [COLOR_W-1:0] rdata;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRANSPARENT_INDEX: cfg_next.transparent_index   = cfg_data[IDX_W-1:0];
                CFG_BACKGROUND_INDEX:  cfg_next.background_index    = cfg_data[IDX_W-1:0];
                CFG_TRANSPARENCY_EN:   cfg_next.transparency_enable = cfg_data[0];
                CFG_RESTORE_BG:        cfg_next.restore_background  = cfg_data[0];
                CFG_DISPLAY_WIDTH:     cfg_next.display_width       = cfg_data[COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transparent_index   <= '0;
            cfg_reg.background_index    <= '0;
            cfg_reg.transparency_enable <= 1'b0;
            cfg_reg.restore_background  <= 1'b0;
            cfg_reg.display_width       <= DISPLAY_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // request handshake
    assign request.ready = free;
    assign accept        = request.valid && free;
    assign pal_we        = accept && (request.command == CMD_PALETTE);

    plbt_line_ctrl u_line_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (request.command),
        .index      (request.index),
        .origin_x   (request.origin_x),
        .row        (request.row),
        .line_width (request.line_width),
        .cfg        (cfg_reg),
        .lookup     (lookup)
    );

    plbt_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (request.index),
        .wdata (request.color),
        .re    (lookup.valid),
        .raddr (lookup.index),
        .rdata (rdata)
    );

    plbt_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .lookup   (lookup),
        .rdata    (rdata),
        .free     (free),
        .response (response)
    );

endmodule

`default_nettype wire

@@ rtl/core/plbt_palette_ram.sv @@
// ----------------------------------------------------------------------------
// plbt_palette_ram
// Color store with one write port and one registered read port; indexes
// beyond the store ignore writes and read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module plbt_palette_ram
    import plbt_pkg::*;
#(
    parameter int ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [IDX_W-1:0]   waddr,
    input  wire logic [COLOR_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [IDX_W-1:0]   raddr,
    output logic      [COLOR_W-1:0] rdata
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [COLOR_W-1:0] mem [ENTRIES];
    logic [COLOR_W-1:0] rdata_reg;
    logic               oob_reg;
    logic               w_in_range;
    logic               r_in_range;

    // range checks against the store depth
    assign w_in_range = ({1'b0, waddr} < (IDX_W+1)'(ENTRIES));
    assign r_in_range = ({1'b0, raddr} < (IDX_W+1)'(ENTRIES));

    // write port
    always_ff @(posedge clk)
    begin
        if (we && w_in_range)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr[AW-1:0]];
            oob_reg   <= !r_in_range;
        end
    end

    assign rdata = oob_reg ? '0 : rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/plbt_line_ctrl.sv @@
// ----------------------------------------------------------------------------
// plbt_line_ctrl
// Line origin, row, clipped width and pixel position; decides per pixel
// whether it is drawn and which palette entry it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module plbt_line_ctrl
    import plbt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [IDX_W-1:0]    index,
    input  wire logic [COORD_W-1:0]  origin_x,
    input  wire logic [COORD_W-1:0]  row,
    input  wire logic [COORD_W-1:0]  line_width,
    input  wire cfg_t                cfg,
    output lookup_t                  lookup
);

    logic [COORD_W-1:0] origin_reg, origin_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] clip_reg, clip_next;
    logic [COORD_W-1:0] pos_reg, pos_next;
    logic [COORD_W:0]   width_disp;
    logic [COORD_W:0]   width_max;
    logic               in_line;
    logic               is_transparent;
    logic               skip;
    logic [IDX_W-1:0]   eff_index;

    // clip the line width to the display and to the longest line
    always_comb
    begin
        width_disp = ({1'b0, line_width} > {1'b0, cfg.display_width})
                   ? {1'b0, cfg.display_width} : {1'b0, line_width};
        width_max  = (width_disp > (COORD_W+1)'(MAX_LINE))
                   ? (COORD_W+1)'(MAX_LINE) : width_disp;
    end

    // transparency key and background substitution
    assign in_line        = (pos_reg < clip_reg);
    assign is_transparent = (index == cfg.transparent_index);
    assign skip           = !cfg.restore_background && cfg.transparency_enable
                            && is_transparent;
    assign eff_index      = (cfg.restore_background && is_transparent)
                          ? cfg.background_index : index;

    // line state update and lookup issue
    always_comb
    begin
        origin_next   = origin_reg;
        row_next      = row_reg;
        clip_next     = clip_reg;
        pos_next      = pos_reg;
        lookup.valid  = 1'b0;
        lookup.index  = eff_index;
        lookup.column = {1'b0, origin_reg} + {1'b0, pos_reg};
        lookup.row    = row_reg;
        if (accept)
        begin
            case (command)
                CMD_LINE:
                begin
                    origin_next = origin_x;
                    row_next    = row;
                    clip_next   = width_max[COORD_W-1:0];
                    pos_next    = '0;
                end
                CMD_PIXEL:
                begin
                    if (in_line)
                    begin
                        pos_next     = pos_reg + COORD_W'(1);
                        lookup.valid = !skip;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            row_reg    <= '0;
            clip_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            origin_reg <= origin_next;
            row_reg    <= row_next;
            clip_reg   <= clip_next;
            pos_reg    <= pos_next;
        end
    end

    // position never runs past the clipped width
    a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= clip_reg)
        else $error("pixel position beyond clipped width");

    // a line start never leaves a width wider than the display
    a_clip_display: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_LINE) |=> clip_reg <= $past(cfg.display_width))
        else $error("clipped width exceeds display width");

    // every pixel inside the line advances the position, drawn or skipped
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_PIXEL && in_line)
        |=> pos_reg == $past(pos_reg) + COORD_W'(1))
        else $error("pixel inside line did not advance position");

endmodule

`default_nettype wire

@@ rtl/core/plbt_out_stage.sv @@
// ----------------------------------------------------------------------------
// plbt_out_stage
// Lookup stage that waits on the palette read, then the output register
// that swaps the color bytes and drives the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module plbt_out_stage
    import plbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lookup_t            lookup,
    input  wire logic [COLOR_W-1:0] rdata,
    output logic                    free,
    plbt_response_if.source         response
);

    logic                s1_valid_reg, s1_valid_next;
    logic [COLUMN_W-1:0] s1_column_reg;
    logic [COORD_W-1:0]  s1_row_reg;
    logic                s2_valid_reg, s2_valid_next;
    logic [COLOR_W-1:0]  s2_color_reg;
    logic [COLUMN_W-1:0] s2_column_reg;
    logic [COORD_W-1:0]  s2_row_reg;
    logic                s1_adv;

    // stage handoff
    assign s1_adv = s1_valid_reg && (!s2_valid_reg || response.ready);
    assign free   = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = lookup.valid || (s1_valid_reg && !s1_adv);
        s2_valid_next = s1_adv || (s2_valid_reg && !response.ready);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload: coordinates wait beside the palette read
    always_ff @(posedge clk)
    begin
        if (lookup.valid)
        begin
            s1_column_reg <= lookup.column;
            s1_row_reg    <= lookup.row;
        end
        if (s1_adv)
        begin
            s2_color_reg  <= {rdata[7:0], rdata[15:8]};
            s2_column_reg <= s1_column_reg;
            s2_row_reg    <= s1_row_reg;
        end
    end

    assign response.valid       = s2_valid_reg;
    assign response.pixel_color = s2_color_reg;
    assign response.column      = s2_column_reg;
    assign response.row_out     = s2_row_reg;

    // a lookup is only issued when the lookup stage can take it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(lookup.valid && s1_valid_reg && !s1_adv))
        else $error("lookup issued into a full stage");

    // a handoff always fills the output register
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> s2_valid_reg)
        else $error("handoff lost");

    // a waiting lookup is held while the output is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && !response.ready) |=> s1_valid_reg)
        else $error("waiting lookup dropped under stall");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the palette line blitter. Requests go in on the
// request channel and the bench keeps its own palette, line state and
// register copy to predict each pixel write. Responses are checked field by
// field in order. Directed tests cover reset state, clipping, transparency
// and background restore. Random lines follow under several register
// settings, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_top;
    import plbt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 85;

    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one expected pixel write
    typedef struct packed {
        logic [COLOR_W-1:0]  pixel_color;
        logic [COLUMN_W-1:0] column;
        logic [COORD_W-1:0]  row_out;
    } pixel_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    plbt_request_if  req_if ();
    plbt_response_if rsp_if ();

    palette_line_blit_transparency_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_if),
        .response  (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bench copy of the block state
    logic [COLOR_W-1:0] palette_copy [256];
    logic [COORD_W-1:0] line_origin_q;
    logic [COORD_W-1:0] line_row_q;
    logic [COORD_W-1:0] line_limit_q;
    logic [COORD_W-1:0] line_pos_q;
    cfg_t               regs_q;

    pixel_write_t pending_writes [$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  burst_left;
    bit           sender_bursty;
    bit           hold_off_req;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d writes pending", $time,
                     pending_writes.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // track one accepted request and queue the pixel write it causes
    function automatic void track_request(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] color,
                                          input logic [COORD_W-1:0] ox,
                                          input logic [COORD_W-1:0] rw,
                                          input logic [COORD_W-1:0] lw);
        logic [IDX_W-1:0]   lookup;
        logic [COLOR_W-1:0] entry;
        logic [COORD_W-1:0] pos;
        pixel_write_t       wr;
        case (cmd)
            CMD_PALETTE: palette_copy[idx] = color;
            CMD_LINE:
            begin
                line_origin_q = ox;
                line_row_q    = rw;
                line_limit_q  = (lw > regs_q.display_width) ? regs_q.display_width : lw;
                line_pos_q    = '0;
            end
            CMD_PIXEL:
            begin
                if (line_pos_q < line_limit_q)
                begin
                    pos        = line_pos_q;
                    line_pos_q = line_pos_q + 1'b1;
                    lookup     = idx;
                    if (regs_q.restore_background && idx == regs_q.transparent_index)
                        lookup = regs_q.background_index;
                    // skipped pixels still take a column
                    if (regs_q.restore_background || !regs_q.transparency_enable ||
                        idx != regs_q.transparent_index)
                    begin
                        entry          = palette_copy[lookup];
                        wr.pixel_color = {entry[7:0], entry[15:8]};
                        wr.column      = COLUMN_W'(line_origin_q) + COLUMN_W'(pos);
                        wr.row_out     = line_row_q;
                        pending_writes.push_back(wr);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // send one request transaction, with bursts and gaps on the way
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [IDX_W-1:0] idx,
                                input logic [COLOR_W-1:0] color,
                                input logic [COORD_W-1:0] ox,
                                input logic [COORD_W-1:0] rw,
                                input logic [COORD_W-1:0] lw);
        int unsigned gap;
        if (sender_bursty && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0)
            burst_left--;
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.index      <= idx;
        req_if.color      <= color;
        req_if.origin_x   <= ox;
        req_if.row        <= rw;
        req_if.line_width <= lw;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        track_request(cmd, idx, color, ox, rw, lw);
    endtask

    task automatic send_pixel(input logic [IDX_W-1:0] idx);
        send_request(CMD_PIXEL, idx, COLOR_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic send_line(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] rw,
                             input logic [COORD_W-1:0] lw);
        send_request(CMD_LINE, IDX_W'($urandom), COLOR_W'($urandom), ox, rw, lw);
    endtask

    task automatic send_palette(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] color);
        send_request(CMD_PALETTE, idx, color, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
    endtask

    task automatic send_unused();
        send_request(CMD_UNUSED, IDX_W'($urandom), COLOR_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // stop sending and let every expected write come out
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (which)
            CFG_TRANSPARENT_INDEX: regs_q.transparent_index   = value[IDX_W-1:0];
            CFG_BACKGROUND_INDEX:  regs_q.background_index    = value[IDX_W-1:0];
            CFG_TRANSPARENCY_EN:   regs_q.transparency_enable = value[0];
            CFG_RESTORE_BG:        regs_q.restore_background  = value[0];
            CFG_DISPLAY_WIDTH:     regs_q.display_width       = value[COORD_W-1:0];
            default: ;
        endcase
    endtask

    // drain, then load all five registers
    task automatic set_registers(input logic [IDX_W-1:0] ti, input logic [IDX_W-1:0] bg,
                                 input logic te, input logic rb,
                                 input logic [COORD_W-1:0] dw);
        wait_idle();
        write_register(CFG_TRANSPARENT_INDEX, CFG_DATA_W'(ti));
        write_register(CFG_BACKGROUND_INDEX, CFG_DATA_W'(bg));
        write_register(CFG_TRANSPARENCY_EN, CFG_DATA_W'(te));
        write_register(CFG_RESTORE_BG, CFG_DATA_W'(rb));
        write_register(CFG_DISPLAY_WIDTH, CFG_DATA_W'(dw));
    endtask

    // response checker
    always @(posedge clk)
    begin
        pixel_write_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write color %h column %0d row %0d", $time,
                         rsp_if.pixel_color, rsp_if.column, rsp_if.row_out);
                error_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (rsp_if.pixel_color !== want.pixel_color)
                begin
                    $display("%0t: pixel_color expected %h actual %h", $time,
                             want.pixel_color, rsp_if.pixel_color);
                    error_count++;
                end
                if (rsp_if.column !== want.column)
                begin
                    $display("%0t: column expected %0d actual %0d", $time,
                             want.column, rsp_if.column);
                    error_count++;
                end
                if (rsp_if.row_out !== want.row_out)
                begin
                    $display("%0t: row_out expected %0d actual %0d", $time,
                             want.row_out, rsp_if.row_out);
                    error_count++;
                end
            end
        end
    end

    // response side: stretches of full speed, random stalls and a fixed
    // pattern, plus a long hold-off on request
    initial
    begin
        int unsigned stretch_left;
        int unsigned mode;
        int unsigned beat;
        stretch_left = 0;
        mode         = 0;
        beat         = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode         = $urandom_range(0, 2);
                    stretch_left = $urandom_range(10, 60);
                end
                stretch_left--;
                beat++;
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: rsp_if.ready <= (beat % 3) != 0;
                endcase
            end
        end
    end

    // pixels before any line, an ignored command and an empty line
    task automatic test_fresh_reset();
        send_pixel(8'h00);
        send_unused();
        send_line(10'd0, 10'd0, 10'd0);
        send_pixel(8'hFF);
    endtask

    // every palette entry gets written before any lookup
    task automatic test_palette_load();
        logic [COLOR_W-1:0] color;
        for (int i = 0; i < 256; i++)
        begin
            case (i)
                0:       color = 16'h0000;
                1:       color = 16'h00FF;
                2:       color = 16'hFF00;
                255:     color = 16'hFFFF;
                default: color = COLOR_W'($urandom);
            endcase
            send_palette(IDX_W'(i), color);
        end
    endtask

    // line width clipped to the default display width, dropped pixels
    task automatic test_line_clipping();
        send_line(10'd0, 10'd0, 10'd4);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'h02);
        send_pixel(8'h05);
        send_line(10'd1023, 10'd1023, 10'd1023);
        for (int i = 0; i < 3; i++)
            send_pixel(IDX_W'($urandom));
        send_line(10'd10, 10'd512, 10'd3);
        send_pixel(8'h10);
        // new line start mid-line restarts the column count
        send_line(10'd20, 10'd513, 10'd2);
        for (int i = 0; i < 3; i++)
            send_pixel(IDX_W'($urandom));
    endtask

    // skipped transparent pixels still advance the column
    task automatic test_transparency_skip();
        set_registers(8'd7, 8'd0, 1'b1, 1'b0, 10'd128);
        send_line(10'd100, 10'd5, 10'd6);
        send_pixel(8'd7);
        send_pixel(8'd1);
        send_pixel(8'd7);
        send_pixel(8'd7);
        send_pixel(8'd200);
        send_pixel(8'd7);
        set_registers(8'd0, 8'd0, 1'b1, 1'b0, 10'd128);
        send_line(10'd3, 10'd9, 10'd2);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    // restore to background swaps the index, with and without transparency
    task automatic test_background_restore();
        set_registers(8'd255, 8'd0, 1'b0, 1'b1, 10'd128);
        send_line(10'd50, 10'd60, 10'd3);
        send_pixel(8'd255);
        send_pixel(8'd3);
        send_pixel(8'd255);
        set_registers(8'd0, 8'd255, 1'b1, 1'b1, 10'd128);
        send_line(10'd70, 10'd80, 10'd2);
        send_pixel(8'd0);
        send_pixel(8'd1);
    endtask

    // narrowest, zero and widest display
    task automatic test_display_width();
        set_registers(8'd0, 8'd0, 1'b0, 1'b0, 10'd1);
        send_line(10'd5, 10'd6, 10'd1023);
        send_pixel(8'd4);
        send_pixel(8'd5);
        set_registers(8'd0, 8'd0, 1'b0, 1'b0, 10'd0);
        send_line(10'd5, 10'd6, 10'd100);
        send_pixel(8'd4);
        set_registers(8'd0, 8'd0, 1'b0, 1'b0, 10'd1023);
        send_line(10'd1023, 10'd0, 10'd1023);
        for (int i = 0; i < 20; i++)
            send_pixel(IDX_W'($urandom));
    endtask

    // long response stall with requests offered back to back
    task automatic test_backpressure();
        set_registers(8'd0, 8'd0, 1'b0, 1'b0, 10'd1023);
        sender_bursty = 1'b0;
        send_line(10'd300, 10'd77, 10'd200);
        hold_off_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pixel(IDX_W'($urandom));
        sender_bursty = 1'b1;
        wait_idle();
    endtask

    // random lines under changing register settings
    task automatic test_random_lines();
        int unsigned        sent;
        int unsigned        pick;
        int unsigned        npix;
        logic [COORD_W-1:0] dw;
        logic [COORD_W-1:0] lw;
        logic [COORD_W-1:0] limit;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_registers(8'd0, 8'd255, 1'b1, 1'b0, 10'd1);
                1: set_registers(8'd255, 8'd0, 1'b0, 1'b1, 10'd1023);
                default:
                begin
                    dw = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 1023))
                                                     : COORD_W'($urandom_range(1, 64));
                    set_registers(IDX_W'($urandom), IDX_W'($urandom),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dw);
                end
            endcase
            sender_bursty = (phase % 3) != 2;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_unused();
                else if (pick <= 2)
                begin
                    send_palette(IDX_W'($urandom), COLOR_W'($urandom));
                    sent++;
                end
                else if (pick <= 4)
                begin
                    send_pixel(IDX_W'($urandom));
                    sent++;
                end
                else
                begin
                    // well-formed line: start, then pixels up to and just past the end, at most 40
                    lw = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 1023))
                                                     : COORD_W'($urandom_range(0, 24));
                    send_line(COORD_W'($urandom), COORD_W'($urandom), lw);
                    limit = (lw > regs_q.display_width) ? regs_q.display_width : lw;
                    npix  = limit + $urandom_range(0, 2);
                    if (npix > 40)
                        npix = 40;
                    for (int i = 0; i < npix; i++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            send_pixel(regs_q.transparent_index);
                        else
                            send_pixel(IDX_W'($urandom));
                    end
                    sent += 1 + npix;
                end
            end
        end
    endtask

    // test sequence
    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_TRANSPARENT_INDEX;
        cfg_data             <= '0;
        req_if.valid         <= 1'b0;
        req_if.command       <= CMD_PALETTE;
        req_if.index         <= '0;
        req_if.color         <= '0;
        req_if.origin_x      <= '0;
        req_if.row           <= '0;
        req_if.line_width    <= '0;
        regs_q.transparent_index   = '0;
        regs_q.background_index    = '0;
        regs_q.transparency_enable = 1'b0;
        regs_q.restore_background  = 1'b0;
        regs_q.display_width       = DISPLAY_WIDTH_RST;
        line_origin_q = '0;
        line_row_q    = '0;
        line_limit_q  = '0;
        line_pos_q    = '0;
        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        sender_bursty = 1'b1;
        hold_off_req  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_reset();
        test_palette_load();
        test_line_clipping();
        test_transparency_skip();
        test_background_restore();
        test_display_width();
        test_backpressure();
        test_random_lines();
        wait_idle();

        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/plbt_pkg.sv
rtl/core/plbt_if.sv
rtl/core/plbt_palette_ram.sv
rtl/core/plbt_line_ctrl.sv
rtl/core/plbt_out_stage.sv
rtl/core/palette_line_blit_transparency_core.sv
tb/sv/tb_top.sv
